@@ rtl/ant_pkg.sv @@
`default_nettype none

package ant_pkg;

    // opcodes of an input beat
    localparam logic [2:0] OP_ANNOUNCE = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_PIN      = 3'd2;
    localparam logic [2:0] OP_UNPIN    = 3'd3;
    localparam logic [2:0] OP_LOOKUP   = 3'd4;
    localparam logic [2:0] OP_FLUSH    = 3'd5;

    // result status codes
    localparam logic [2:0] STS_DONE      = 3'd0;
    localparam logic [2:0] STS_INSERTED  = 3'd1;
    localparam logic [2:0] STS_OWN       = 3'd2;
    localparam logic [2:0] STS_DROPPED   = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;

    // configuration register indexes
    localparam logic [7:0] CFG_STALE_AGE = 8'd0;
    localparam logic [7:0] CFG_OWN_HIGH  = 8'd1;
    localparam logic [7:0] CFG_OWN_LOW   = 8'd2;
    localparam logic [7:0] CFG_OWN_EN    = 8'd3;

    localparam logic [31:0] STALE_AGE_RESET = 32'd3600000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_STALE,
        ST_OLDEST,
        ST_APPEND,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [31:0] seen;
        logic [7:0]  hops;
        logic        pinned;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic wr_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/ant_cell.sv @@
`default_nettype none

module ant_cell #(
    parameter int DEPTH = 32,
    parameter int IDX   = 0
) (
    input  wire logic                         aclk,
    input  wire ant_pkg::cell_ctrl_t          ctrl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   cnt,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_idx,
    input  wire ant_pkg::entry_t              up,
    input  wire ant_pkg::entry_t              wr_data,
    output ant_pkg::entry_t                   q
);
    import ant_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
    localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

    entry_t q_reg;

    // write from the head unit wins, else take the neighbour while inside the table
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && wr_idx == MY_IDX) begin
            q_reg <= wr_data;
        end else if (ctrl.shift && NEXT_IDX < cnt) begin
            q_reg <= up;
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

@@ rtl/aging_node_table_core.sv @@
// a beat runs a search pass over all n table entries (n = entries), then its result is registered
// an insert adds an append step; an announce on a full table first runs the stale and oldest passes
// throughput: one beat at a time; the next beat is taken once the result is registered
// each pass pops the head cell once a cycle and rewrites it at the tail of the chain unless it is removed
// reset: synchronous active low; clears occupancy, dirty flag, config and handshake state
`default_nettype none

module aging_node_table_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_opcode,
    input  wire logic [63:0] s_key_high,
    input  wire logic [63:0] s_key_low,
    input  wire logic [31:0] s_now_ms,
    input  wire logic [7:0]  s_hop_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [7:0]       m_found_hops,
    output logic [31:0]      m_found_last_seen,
    output logic             m_found_pinned,
    output logic [5:0]       m_entry_total,
    output logic [5:0]       m_removed_total,
    output logic             m_was_dirty
);
    import ant_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    // configuration
    logic [31:0] stale_reg;
    logic [63:0] own_hi_reg, own_lo_reg;
    logic        own_en_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_reg  <= STALE_AGE_RESET;
            own_hi_reg <= '0;
            own_lo_reg <= '0;
            own_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STALE_AGE: stale_reg  <= cfg_data[31:0];
                CFG_OWN_HIGH:  own_hi_reg <= cfg_data;
                CFG_OWN_LOW:   own_lo_reg <= cfg_data;
                CFG_OWN_EN:    own_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [IW-1:0]  pos_reg, pos_next;
    logic [IW-1:0]  pick_reg, pick_next;
    logic           have_reg, have_next;
    logic [31:0]    min_reg, min_next;
    logic [CW-1:0]  removed_reg, removed_next;
    logic           dirty_reg, dirty_next;
    logic           found_reg, found_next;
    logic           own_reg, own_next;
    logic [2:0]     status_reg, status_next;
    logic           was_reg, was_next;
    logic [7:0]     fhops_reg, fhops_next;
    logic [31:0]    fseen_reg, fseen_next;
    logic           fpin_reg, fpin_next;
    logic [2:0]     op_reg, op_next;
    logic [63:0]    kh_reg, kh_next, kl_reg, kl_next;
    logic [31:0]    now_reg, now_next;
    logic [7:0]     hop_reg, hop_next;
    logic           mv_reg, mv_next;
    logic [2:0]     ms_reg, ms_next;
    logic [7:0]     mh_reg, mh_next;
    logic [31:0]    mt_reg, mt_next;
    logic           mp_reg, mp_next;
    logic [5:0]     me_reg, me_next, mr_reg, mr_next;
    logic           md_reg, md_next;

    // chain of cells
    cell_ctrl_t     ctrl;
    logic [IW-1:0]  wr_idx;
    entry_t         wr_data;
    entry_t         cell_q [TABLE_DEPTH];
    entry_t         head;
    logic           match;
    logic [31:0]    age;
    logic           ins;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        entry_t up;
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign up = cell_q[i];
        end else begin : g_mid
            assign up = cell_q[i+1];
        end
        ant_cell #(.DEPTH(TABLE_DEPTH), .IDX(i)) u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .cnt     (cnt_reg),
            .wr_idx  (wr_idx),
            .up      (up),
            .wr_data (wr_data),
            .q       (cell_q[i])
        );
    end

    assign head  = cell_q[0];
    assign match = (head.key_high == kh_reg) && (head.key_low == kl_reg);
    assign age   = now_reg - head.seen;
    assign ins   = !own_reg && !found_reg && (op_reg == OP_ANNOUNCE || op_reg == OP_ADD);

    // next state and datapath control
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        pick_next    = pick_reg;
        have_next    = have_reg;
        min_next     = min_reg;
        removed_next = removed_reg;
        dirty_next   = dirty_reg;
        found_next   = found_reg;
        own_next     = own_reg;
        status_next  = status_reg;
        was_next     = was_reg;
        fhops_next   = fhops_reg;
        fseen_next   = fseen_reg;
        fpin_next    = fpin_reg;
        op_next      = op_reg;
        kh_next      = kh_reg;
        kl_next      = kl_reg;
        now_next     = now_reg;
        hop_next     = hop_reg;
        mv_next      = mv_reg && !m_ready;
        ms_next      = ms_reg;
        mh_next      = mh_reg;
        mt_next      = mt_reg;
        mp_next      = mp_reg;
        me_next      = me_reg;
        mr_next      = mr_reg;
        md_next      = md_reg;
        ctrl         = '0;
        wr_idx       = IW'(cnt_reg - CW'(1));
        wr_data      = head;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next      = s_opcode;
                    kh_next      = s_key_high;
                    kl_next      = s_key_low;
                    now_next     = s_now_ms;
                    hop_next     = s_hop_count;
                    own_next     = own_en_reg && s_opcode == OP_ANNOUNCE
                                   && s_key_high == own_hi_reg && s_key_low == own_lo_reg;
                    was_next     = dirty_reg;
                    found_next   = 1'b0;
                    fhops_next   = '0;
                    fseen_next   = '0;
                    fpin_next    = 1'b0;
                    removed_next = '0;
                    rem_next     = cnt_reg;
                    status_next  = STS_NOT_FOUND;
                    if (s_opcode == OP_FLUSH) begin
                        status_next = STS_DONE;
                        dirty_next  = 1'b0;
                    end else if (own_en_reg && s_opcode == OP_ANNOUNCE
                                 && s_key_high == own_hi_reg && s_key_low == own_lo_reg) begin
                        status_next = STS_OWN;
                    end
                    state_next = ST_FIND;
                end
            end

            // search pass, the hit entry is modified on its way round
            ST_FIND: begin
                if (rem_reg != '0) begin
                    ctrl.shift = 1'b1;
                    ctrl.wr_en = 1'b1;
                    rem_next   = rem_reg - CW'(1);
                    if (match && !own_reg && op_reg <= OP_LOOKUP) begin
                        found_next  = 1'b1;
                        status_next = STS_DONE;
                        unique case (op_reg)
                            OP_ANNOUNCE: begin
                                wr_data.seen = now_reg;
                                wr_data.hops = hop_reg;
                                if (head.pinned) dirty_next = 1'b1;
                            end
                            OP_ADD, OP_PIN: wr_data.pinned = 1'b1;
                            OP_UNPIN:       wr_data.pinned = 1'b0;
                            default: begin
                                fhops_next = head.hops;
                                fseen_next = head.seen;
                                fpin_next  = head.pinned;
                            end
                        endcase
                    end
                end else if (ins && op_reg == OP_ANNOUNCE && cnt_reg == FULL) begin
                    rem_next   = cnt_reg;
                    pos_next   = '0;
                    have_next  = 1'b0;
                    state_next = ST_STALE;
                end else if (ins) begin
                    state_next = ST_APPEND;
                end else begin
                    state_next = ST_RESP;
                end
            end

            // stale pass, also tracks the oldest surviving unpinned entry
            ST_STALE: begin
                if (rem_reg != '0) begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - CW'(1);
                    pos_next   = pos_reg + IW'(1);
                    if (!head.pinned && age > stale_reg) begin
                        cnt_next     = cnt_reg - CW'(1);
                        removed_next = removed_reg + CW'(1);
                    end else begin
                        ctrl.wr_en = 1'b1;
                        if (!head.pinned && (!have_reg || head.seen < min_reg)) begin
                            min_next  = head.seen;
                            pick_next = pos_reg;
                            have_next = 1'b1;
                        end
                    end
                end else if (cnt_reg == FULL && have_reg) begin
                    rem_next   = cnt_reg;
                    pos_next   = '0;
                    state_next = ST_OLDEST;
                end else begin
                    state_next = ST_APPEND;
                end
            end

            // eviction pass for the chosen oldest entry
            ST_OLDEST: begin
                if (rem_reg != '0) begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - CW'(1);
                    pos_next   = pos_reg + IW'(1);
                    if (pos_reg == pick_reg) begin
                        cnt_next     = cnt_reg - CW'(1);
                        removed_next = removed_reg + CW'(1);
                    end else begin
                        ctrl.wr_en = 1'b1;
                    end
                end else begin
                    state_next = ST_APPEND;
                end
            end

            ST_APPEND: begin
                if (cnt_reg != FULL) begin
                    ctrl.wr_en       = 1'b1;
                    wr_idx           = IW'(cnt_reg);
                    wr_data.key_high = kh_reg;
                    wr_data.key_low  = kl_reg;
                    wr_data.seen     = now_reg;
                    wr_data.hops     = (op_reg == OP_ANNOUNCE) ? hop_reg : 8'd0;
                    wr_data.pinned   = (op_reg == OP_ADD);
                    cnt_next         = cnt_reg + CW'(1);
                    status_next      = STS_INSERTED;
                end else begin
                    status_next = STS_DROPPED;
                end
                state_next = ST_RESP;
            end

            // result register, freed while the next beat is worked on
            ST_RESP: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = status_reg;
                    mh_next    = fhops_reg;
                    mt_next    = fseen_reg;
                    mp_next    = fpin_reg;
                    me_next    = 6'(cnt_reg);
                    mr_next    = 6'(removed_reg);
                    md_next    = was_reg;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            dirty_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            dirty_reg <= dirty_next;
            mv_reg    <= mv_next;
        end
    end

    // working and result payload
    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        pick_reg    <= pick_next;
        have_reg    <= have_next;
        min_reg     <= min_next;
        removed_reg <= removed_next;
        found_reg   <= found_next;
        own_reg     <= own_next;
        status_reg  <= status_next;
        was_reg     <= was_next;
        fhops_reg   <= fhops_next;
        fseen_reg   <= fseen_next;
        fpin_reg    <= fpin_next;
        op_reg      <= op_next;
        kh_reg      <= kh_next;
        kl_reg      <= kl_next;
        now_reg     <= now_next;
        hop_reg     <= hop_next;
        ms_reg      <= ms_next;
        mh_reg      <= mh_next;
        mt_reg      <= mt_next;
        mp_reg      <= mp_next;
        me_reg      <= me_next;
        mr_reg      <= mr_next;
        md_reg      <= md_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = mv_reg;
    assign m_status          = ms_reg;
    assign m_found_hops      = mh_reg;
    assign m_found_last_seen = mt_reg;
    assign m_found_pinned    = mp_reg;
    assign m_entry_total     = me_reg;
    assign m_removed_total   = mr_reg;
    assign m_was_dirty       = md_reg;

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FULL) else $error("occupancy beyond table depth");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> rem_reg <= cnt_reg)
        else $error("pass count beyond occupancy");

    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("second beat taken during work");

    a_removed_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_removed_total != 6'd0) |->
        (m_status == STS_INSERTED || m_status == STS_DROPPED))
        else $error("eviction without insert attempt");

endmodule

`default_nettype wire
